/* hdl/tbp_pkg.sv */
// Shared constants for the tournament branch predictor.
// Default table geometry and counter widths; no dependencies.
package tbp_pkg;

  localparam int PC_INDEX_BITS_DEF       = 10;
  localparam int LOCAL_HISTORY_BITS_DEF  = 10;
  localparam int GLOBAL_HISTORY_BITS_DEF = 12;
  localparam int LOCAL_COUNTER_BITS_DEF  = 3;
  localparam int GLOBAL_COUNTER_BITS_DEF = 2;
  localparam int CHOOSER_BITS            = 2;
  localparam int ADDRESS_BITS            = 32;

endpackage

/* hdl/tbp_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// Read data holds while the read enable is low. No dependencies.
module tbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/tournament_branch_predictor.sv */
// Tournament branch predictor top level: local, global and chooser tables in RAM.
// Depends on tbp_pkg and tbp_ram.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+--------------------------------------
//   branch   | branch_valid, branch_stall | branch_address, conditional, outcome
//   pred     | pred_valid, pred_stall     | prediction
//
// Each branch passes through these steps: accept and read the local history and
// global/chooser entry, read the local counter addressed by that history,
// then predict and write back all three tables.
// After reset a clearing pass zeroes every table, one entry per cycle, over
// 2**max(PC_INDEX_BITS, LOCAL_HISTORY_BITS, GLOBAL_HISTORY_BITS) addresses
// (4096 at the defaults); no branch is accepted meanwhile.
// The write-back waits while a previous prediction is still stalled.
module tournament_branch_predictor
  import tbp_pkg::*;
#(
  parameter int PC_INDEX_BITS       = PC_INDEX_BITS_DEF,
  parameter int LOCAL_HISTORY_BITS  = LOCAL_HISTORY_BITS_DEF,
  parameter int GLOBAL_HISTORY_BITS = GLOBAL_HISTORY_BITS_DEF,
  parameter int LOCAL_COUNTER_BITS  = LOCAL_COUNTER_BITS_DEF,
  parameter int GLOBAL_COUNTER_BITS = GLOBAL_COUNTER_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    branch_valid,
  output logic                    branch_stall,
  input  logic [ADDRESS_BITS-1:0] branch_address,
  input  logic                    conditional,
  input  logic                    outcome,
  output logic                    pred_valid,
  input  logic                    pred_stall,
  output logic                    prediction
);

  localparam int PL_BITS  = (PC_INDEX_BITS > LOCAL_HISTORY_BITS) ?
                            PC_INDEX_BITS : LOCAL_HISTORY_BITS;
  localparam int CLR_BITS = (PL_BITS > GLOBAL_HISTORY_BITS) ? PL_BITS : GLOBAL_HISTORY_BITS;
  localparam int GW       = GLOBAL_COUNTER_BITS + CHOOSER_BITS;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_LHIST, S_UPDATE} state_t;

  state_t                         state;
  logic [CLR_BITS-1:0]            clr_addr;
  logic [PC_INDEX_BITS-1:0]       pc;
  logic                           cond;
  logic                           taken;
  logic [GLOBAL_HISTORY_BITS-1:0] ghist;
  logic                           last_local;
  logic                           last_global;
  logic                           last_pred;

  logic                           lht_we, lct_we, gt_we;
  logic [PC_INDEX_BITS-1:0]       lht_waddr;
  logic [LOCAL_HISTORY_BITS-1:0]  lht_wdata, lht_rdata;
  logic [LOCAL_HISTORY_BITS-1:0]  lct_waddr;
  logic [LOCAL_COUNTER_BITS-1:0]  lct_wdata, lct_rdata;
  logic [GLOBAL_HISTORY_BITS-1:0] gt_waddr;
  logic [GW-1:0]                  gt_wdata, gt_rdata;

  logic                           accept;
  logic                           advance;
  logic [GLOBAL_COUNTER_BITS-1:0] gc;
  logic [CHOOSER_BITS-1:0]        ch;
  logic                           local_guess, global_guess, pred_next;
  logic [LOCAL_COUNTER_BITS-1:0]  lc_next;
  logic [GLOBAL_COUNTER_BITS-1:0] gc_next;
  logic [CHOOSER_BITS-1:0]        ch_next;
  logic [LOCAL_HISTORY_BITS-1:0]  lh_next;
  logic [GLOBAL_HISTORY_BITS-1:0] ghist_next;
  logic                           clearing;

  assign branch_stall = (state != S_IDLE);
  assign accept       = branch_valid && !branch_stall;
  assign advance      = (state == S_UPDATE) && (!pred_valid || !pred_stall);
  assign clearing     = (state == S_CLEAR);

  assign gc = gt_rdata[GW-1:CHOOSER_BITS];
  assign ch = gt_rdata[CHOOSER_BITS-1:0];

  always_comb begin
    if (cond) begin
      local_guess  = lct_rdata[LOCAL_COUNTER_BITS-1];
      global_guess = gc[GLOBAL_COUNTER_BITS-1];
      if (local_guess == global_guess) begin
        pred_next = local_guess;
      end else begin
        pred_next = ch[CHOOSER_BITS-1] ? global_guess : local_guess;
      end
    end else begin
      local_guess  = last_local;
      global_guess = last_global;
      pred_next    = last_pred;
    end

    if (taken) begin
      lc_next = (lct_rdata == '1) ? lct_rdata : lct_rdata + 1'b1;
      gc_next = (gc == '1) ? gc : gc + 1'b1;
    end else begin
      lc_next = (lct_rdata == '0) ? lct_rdata : lct_rdata - 1'b1;
      gc_next = (gc == '0) ? gc : gc - 1'b1;
    end

    if (local_guess == global_guess) begin
      ch_next = ch;
    end else if (local_guess != taken) begin
      ch_next = (ch == '1) ? ch : ch + 1'b1;
    end else begin
      ch_next = (ch == '0) ? ch : ch - 1'b1;
    end

    lh_next    = {lht_rdata[LOCAL_HISTORY_BITS-2:0], taken};
    ghist_next = {ghist[GLOBAL_HISTORY_BITS-2:0], taken};
  end

  always_comb begin
    if (clearing) begin
      lht_we    = (CLR_BITS'(clr_addr >> PC_INDEX_BITS) == '0);
      lct_we    = (CLR_BITS'(clr_addr >> LOCAL_HISTORY_BITS) == '0);
      gt_we     = (CLR_BITS'(clr_addr >> GLOBAL_HISTORY_BITS) == '0);
      lht_waddr = clr_addr[PC_INDEX_BITS-1:0];
      lct_waddr = clr_addr[LOCAL_HISTORY_BITS-1:0];
      gt_waddr  = clr_addr[GLOBAL_HISTORY_BITS-1:0];
      lht_wdata = '0;
      lct_wdata = '0;
      gt_wdata  = '0;
    end else begin
      lht_we    = advance;
      lct_we    = advance;
      gt_we     = advance;
      lht_waddr = pc;
      lct_waddr = lht_rdata;
      gt_waddr  = ghist;
      lht_wdata = lh_next;
      lct_wdata = lc_next;
      gt_wdata  = {gc_next, ch_next};
    end
  end

  tbp_ram #(
    .WIDTH(LOCAL_HISTORY_BITS),
    .DEPTH(1 << PC_INDEX_BITS)
  ) u_lht (
    .clk  (clk),
    .we   (lht_we),
    .waddr(lht_waddr),
    .wdata(lht_wdata),
    .re   (accept),
    .raddr(branch_address[PC_INDEX_BITS+1:2]),
    .rdata(lht_rdata)
  );

  tbp_ram #(
    .WIDTH(LOCAL_COUNTER_BITS),
    .DEPTH(1 << LOCAL_HISTORY_BITS)
  ) u_lct (
    .clk  (clk),
    .we   (lct_we),
    .waddr(lct_waddr),
    .wdata(lct_wdata),
    .re   (state == S_LHIST),
    .raddr(lht_rdata),
    .rdata(lct_rdata)
  );

  tbp_ram #(
    .WIDTH(GW),
    .DEPTH(1 << GLOBAL_HISTORY_BITS)
  ) u_gt (
    .clk  (clk),
    .we   (gt_we),
    .waddr(gt_waddr),
    .wdata(gt_wdata),
    .re   (accept),
    .raddr(ghist),
    .rdata(gt_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      ghist       <= '0;
      last_local  <= 1'b1;
      last_global <= 1'b1;
      last_pred   <= 1'b1;
      pred_valid  <= 1'b0;
    end else begin
      if (advance) begin
        pred_valid <= 1'b1;
      end else if (pred_valid && !pred_stall) begin
        pred_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state <= S_LHIST;
          end
        end
        S_LHIST: begin
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          if (advance) begin
            state       <= S_IDLE;
            ghist       <= ghist_next;
            last_local  <= local_guess;
            last_global <= global_guess;
            last_pred   <= pred_next;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pc    <= branch_address[PC_INDEX_BITS+1:2];
      cond  <= conditional;
      taken <= outcome;
    end
    if (advance) begin
      prediction <= pred_next;
    end
  end

endmodule

/* tb/tournament_branch_predictor_tb.sv */
// Testbench for tournament_branch_predictor: drives branch transactions and checks predictions.
// A scoreboard class keeps its own copy of the local, global and chooser tables to work them out.
// Depends on tbp_pkg and the predictor RTL.
module tournament_branch_predictor_tb
  import tbp_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PCB = PC_INDEX_BITS_DEF;
  localparam int LHB = LOCAL_HISTORY_BITS_DEF;
  localparam int GHB = GLOBAL_HISTORY_BITS_DEF;
  localparam int LCB = LOCAL_COUNTER_BITS_DEF;
  localparam int GCB = GLOBAL_COUNTER_BITS_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOT_PCS = 6;

  class prediction_scoreboard;
    bit [LHB-1:0] local_hist [1 << PCB];
    bit [LCB-1:0] local_ctr [1 << LHB];
    bit [GCB-1:0] global_ctr [1 << GHB];
    bit [CHOOSER_BITS-1:0] chooser [1 << GHB];
    bit [GHB-1:0] global_hist;
    bit last_local;
    bit last_global;
    bit last_pred;
    bit expected_q [$];
    int errors;

    function new();
      foreach (local_hist[i]) local_hist[i] = '0;
      foreach (local_ctr[i]) local_ctr[i] = '0;
      foreach (global_ctr[i]) global_ctr[i] = '0;
      foreach (chooser[i]) chooser[i] = '0;
      global_hist = '0;
      last_local = 1'b1;
      last_global = 1'b1;
      last_pred = 1'b1;
      errors = 0;
    endfunction

    function void note_branch(bit [ADDRESS_BITS-1:0] addr, bit cond, bit taken);
      bit [PCB-1:0] pc;
      bit [LHB-1:0] lh;
      bit [LCB-1:0] lc;
      bit [GCB-1:0] gc;
      bit [CHOOSER_BITS-1:0] ch;
      pc = addr[PCB+1:2];
      lh = local_hist[pc];
      lc = local_ctr[lh];
      gc = global_ctr[global_hist];
      ch = chooser[global_hist];
      if (cond) begin
        last_local = lc[LCB-1];
        last_global = gc[GCB-1];
        if (last_local == last_global)
          last_pred = last_local;
        else
          last_pred = ch[CHOOSER_BITS-1] ? last_global : last_local;
      end
      expected_q.push_back(last_pred);
      if (taken) begin
        if (lc != '1) lc = lc + 1'b1;
        if (gc != '1) gc = gc + 1'b1;
      end else begin
        if (lc != '0) lc = lc - 1'b1;
        if (gc != '0) gc = gc - 1'b1;
      end
      local_ctr[lh] = lc;
      global_ctr[global_hist] = gc;
      if (last_local != last_global) begin
        if (last_local != taken) begin
          if (ch != '1) ch = ch + 1'b1;
        end else begin
          if (ch != '0) ch = ch - 1'b1;
        end
        chooser[global_hist] = ch;
      end
      local_hist[pc] = {lh[LHB-2:0], taken};
      global_hist = {global_hist[GHB-2:0], taken};
    endfunction

    task report_mismatch(string msg);
      $display("ERROR: %s", msg);
      errors++;
    endtask

    task check_prediction(bit pred);
      bit want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("prediction %0b with no transaction outstanding", pred));
      end else begin
        want = expected_q.pop_front();
        if (pred !== want)
          report_mismatch($sformatf("prediction %0b, expected %0b", pred, want));
      end
    endtask
  endclass

  logic                    clk;
  logic                    rst = 1'b1;
  logic                    branch_valid = 1'b0;
  logic                    branch_stall;
  logic [ADDRESS_BITS-1:0] branch_address = '0;
  logic                    conditional = 1'b0;
  logic                    outcome = 1'b0;
  logic                    pred_valid;
  logic                    pred_stall = 1'b0;
  logic                    prediction;

  prediction_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  logic hold_off = 1'b0;
  int cycles = 0;
  bit [PCB-1:0] hot_pc [HOT_PCS];
  int hot_visits [HOT_PCS];

  tournament_branch_predictor dut (
    .clk            (clk),
    .rst            (rst),
    .branch_valid   (branch_valid),
    .branch_stall   (branch_stall),
    .branch_address (branch_address),
    .conditional    (conditional),
    .outcome        (outcome),
    .pred_valid     (pred_valid),
    .pred_stall     (pred_stall),
    .prediction     (prediction)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tournament_branch_predictor_tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && pred_valid && !pred_stall)
      sb.check_prediction(prediction);
    pred_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
  end

  task send_branch(bit [ADDRESS_BITS-1:0] addr, bit cond, bit taken);
    while ($urandom_range(99) < send_idle_pct) begin
      branch_valid <= 1'b0;
      @(posedge clk);
    end
    branch_valid   <= 1'b1;
    branch_address <= addr;
    conditional    <= cond;
    outcome        <= taken;
    do @(posedge clk); while (branch_stall);
    sb.note_branch(addr, cond, taken);
  endtask

  task random_branch();
    bit [ADDRESS_BITS-1:0] addr;
    bit cond;
    bit taken;
    int k;
    addr = $urandom;
    cond = $urandom_range(99) < 88;
    taken = 1'($urandom_range(1));
    if ($urandom_range(99) < 75) begin
      k = $urandom_range(HOT_PCS - 1);
      addr[PCB+1:2] = hot_pc[k];
      case (k)
        0: taken = 1'b1;
        1: taken = 1'b0;
        2: taken = hot_visits[k][0];
        3: taken = (hot_visits[k] % 4) != 3;
        4: taken = $urandom_range(9) != 0;
        default: ;
      endcase
      hot_visits[k]++;
    end
    send_branch(addr, cond, taken);
  endtask

  initial begin
    sb = new();
    foreach (hot_pc[i]) begin
      hot_pc[i] = PCB'($urandom);
      hot_visits[i] = 0;
    end
    send_idle_pct = 35;
    recv_idle_pct = 74;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_branch(32'h0000_0000, 1'b0, 1'b1);
    send_branch(32'hFFFF_FFFF, 1'b1, 1'b0);
    send_branch(32'hFFFF_FFFC, 1'b0, 1'b1);
    send_branch(32'h0000_0003, 1'b1, 1'b1);
    send_branch(32'hFFFF_F003, 1'b1, 1'b0);
    send_branch(32'h0000_0FFC, 1'b1, 1'b1);
    repeat (4) send_branch(32'h8000_0100, 1'b1, 1'b0);
    repeat (12) send_branch(32'h0000_0100, 1'b1, 1'b1);
    send_branch(32'h0000_0100, 1'b0, 1'b0);
    send_branch(32'h5555_5554, 1'b1, 1'b0);
    send_branch(32'hAAAA_AAA8, 1'b0, 1'b1);

    repeat (320) random_branch();
    send_idle_pct = 74;
    recv_idle_pct = 35;
    repeat (320) random_branch();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fork
      begin
        hold_off <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off <= 1'b0;
      end
    join_none
    repeat (310) random_branch();
    branch_valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (sb.errors == 0)
      $display("tournament_branch_predictor_tb OK");
    else
      $display("tournament_branch_predictor_tb NOT OK");
    $finish;
  end

endmodule

/* sim.f */
hdl/tbp_pkg.sv
hdl/tbp_ram.sv
hdl/tournament_branch_predictor.sv
tb/tournament_branch_predictor_tb.sv
